// ===== hw/rtl/hvc_pkg.sv =====
`timescale 1ns / 1ps

package hvc_pkg;

  // Field widths
  localparam int HUM_W   = 7;
  localparam int TEMP_W  = 8;
  localparam int TIME_W  = 16;
  localparam int GAP_W   = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUMIDITY_LOW  = 3'd0,
    REG_HUMIDITY_HIGH = 3'd1,
    REG_TEMP_LOW      = 3'd2,
    REG_TEMP_HIGH     = 3'd3,
    REG_HEAT_ON_LIMIT = 3'd4,
    REG_HEAT_PAUSE    = 3'd5,
    REG_VENT_ON_LIMIT = 3'd6,
    REG_VENT_PAUSE    = 3'd7
  } hvc_reg_t;

  // Reset values of the registers
  localparam logic [HUM_W-1:0]  HUMIDITY_LOW_RST  = 7'd40;
  localparam logic [HUM_W-1:0]  HUMIDITY_HIGH_RST = 7'd45;
  localparam logic [TEMP_W-1:0] TEMP_LOW_RST      = 8'd20;
  localparam logic [TEMP_W-1:0] TEMP_HIGH_RST     = 8'd24;
  localparam logic [TIME_W-1:0] HEAT_ON_LIMIT_RST = 16'd900;
  localparam logic [TIME_W-1:0] HEAT_PAUSE_RST    = 16'd900;
  localparam logic [TIME_W-1:0] VENT_ON_LIMIT_RST = 16'd1200;
  localparam logic [TIME_W-1:0] VENT_PAUSE_RST    = 16'd900;

  typedef struct packed {
    logic        [HUM_W-1:0]  humidity_low;
    logic        [HUM_W-1:0]  humidity_high;
    logic signed [TEMP_W-1:0] temp_low;
    logic signed [TEMP_W-1:0] temp_high;
    logic        [TIME_W-1:0] heat_on_limit;
    logic        [TIME_W-1:0] heat_pause;
    logic        [TIME_W-1:0] vent_on_limit;
    logic        [TIME_W-1:0] vent_pause;
  } hvc_cfg_t;

  typedef struct packed {
    logic              heater_on;
    logic              vent_on;
    logic [TIME_W-1:0] heater_cnt;
    logic [TIME_W-1:0] vent_cnt;
    logic [GAP_W-1:0]  gap_cnt;
    logic              heater_req;
    logic              vent_req;
    logic              heater_out;
    logic              vent_out;
  } hvc_state_t;

endpackage

// ===== hw/rtl/hvc_step.sv =====
`timescale 1ns / 1ps

module hvc_step (
  input  hvc_pkg::hvc_cfg_t                   cfg,
  input  hvc_pkg::hvc_state_t                 cur,
  input  logic [hvc_pkg::GAP_W-1:0]           gap_load,
  input  logic [hvc_pkg::HUM_W-1:0]           humidity,
  input  logic signed [hvc_pkg::TEMP_W-1:0]   temperature,
  input  logic                                manual_mode,
  output hvc_pkg::hvc_state_t                 nxt
);
  import hvc_pkg::*;

  logic [TIME_W-1:0] heater_dec;
  logic [TIME_W-1:0] vent_dec;
  logic [GAP_W-1:0]  gap_dec;
  logic              heat_exp;
  logic              vent_exp;

  // Count down every timer by one tick, stopping at zero
  always_comb begin
    heater_dec = (cur.heater_cnt != '0) ? cur.heater_cnt - 1'b1 : '0;
    vent_dec   = (cur.vent_cnt != '0) ? cur.vent_cnt - 1'b1 : '0;
    gap_dec    = (cur.gap_cnt != '0) ? cur.gap_cnt - 1'b1 : '0;
    heat_exp   = (heater_dec == '0);
    vent_exp   = (vent_dec == '0);
  end

  always_comb begin
    nxt            = cur;
    nxt.heater_cnt = heater_dec;
    nxt.vent_cnt   = vent_dec;
    nxt.gap_cnt    = gap_dec;

    // Heater machine
    if (!cur.heater_on) begin
      if (heat_exp && (temperature < cfg.temp_low ||
                       (humidity > cfg.humidity_high && temperature < cfg.temp_high))) begin
        nxt.heater_cnt = cfg.heat_on_limit;
        nxt.heater_req = 1'b1;
        nxt.heater_on  = 1'b1;
      end
    end else if (heat_exp || temperature > cfg.temp_high) begin
      nxt.heater_cnt = cfg.heat_pause;
      nxt.heater_req = 1'b0;
      nxt.heater_out = 1'b0;
      nxt.heater_on  = 1'b0;
    end

    // Vent machine; manual mode enables without reloading the timer
    if (!cur.vent_on) begin
      if (vent_exp && humidity > cfg.humidity_high) begin
        nxt.vent_cnt = cfg.vent_on_limit;
        nxt.vent_req = 1'b1;
        nxt.vent_on  = 1'b1;
      end
      if (manual_mode) begin
        nxt.vent_req = 1'b1;
        nxt.vent_on  = 1'b1;
      end
    end else if ((vent_exp || humidity < cfg.humidity_low) && !manual_mode) begin
      nxt.vent_cnt = cfg.vent_pause;
      nxt.vent_req = 1'b0;
      nxt.vent_out = 1'b0;
      nxt.vent_on  = 1'b0;
    end

    // Load sequencer: heater first, then vent, one switch-on per gap
    if (gap_dec == '0) begin
      priority if (nxt.heater_req) begin
        nxt.heater_out = 1'b1;
        nxt.heater_req = 1'b0;
        nxt.gap_cnt    = gap_load;
      end else if (nxt.vent_req) begin
        nxt.vent_out = 1'b1;
        nxt.vent_req = 1'b0;
        nxt.gap_cnt  = gap_load;
      end else begin
        // nothing pending: keep the gap timer expired
        nxt.gap_cnt = gap_dec;
      end
    end
  end

endmodule

// ===== hw/rtl/heater_vent_climate_controller.sv =====
`timescale 1ns / 1ps
// Heater and vent controller with hysteresis and a load sequencer.
// Each input word is one one-second tick: humidity, temperature and the
// manual-mode flag. Every tick yields exactly one result word with the load
// drives, the enable state of both machines and the pending switch-ons.
// Channels: in_* and out_* are valid/ready; a word moves when both are high.
// Configuration: cfg_we writes cfg_data into register cfg_index at the
// clock edge; write only while no tick is in flight.
// Path: a tick is captured in the input register, then the state update
// moves its result into the output register, where it waits to be taken.
// Throughput: one tick per cycle while out_ready is high; the state is
// updated by compare and decrement logic, so ticks follow back to back.
// Stall: while out_ready is low the result holds; one more tick waits in
// the input register, after which in_ready drops.
// Reset (rst_n low, synchronous): registers return to their defaults, both
// machines disabled, both timers at START_HOLD_TICKS, gap timer expired,
// no requests and both loads off; both pipeline stages empty.
module heater_vent_climate_controller #(
  parameter int LOAD_GAP_TICKS   = 10,
  parameter int START_HOLD_TICKS = 30
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hvc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hvc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hvc_pkg::HUM_W-1:0]         in_humidity,
  input  logic signed [hvc_pkg::TEMP_W-1:0] in_temperature,
  input  logic                              in_manual_mode,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_heater_drive,
  output logic                              out_vent_drive,
  output logic                              out_heater_active,
  output logic                              out_vent_active,
  output logic                              out_heater_pending,
  output logic                              out_vent_pending
);
  import hvc_pkg::*;

  localparam logic [GAP_W-1:0]  GapLoad   = GAP_W'(LOAD_GAP_TICKS);
  localparam logic [TIME_W-1:0] StartHold = TIME_W'(START_HOLD_TICKS);

  hvc_cfg_t   cfg_r;
  hvc_state_t st_r;
  hvc_state_t st_nxt;

  logic                     s1_valid_r;
  logic [HUM_W-1:0]         s1_hum_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  logic                     s1_manual_r;
  logic                     out_valid_r;
  logic [5:0]               out_word_r;

  logic out_free;
  logic s1_adv;

  // Advance stage one when the output register is empty or being taken
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.humidity_low  <= HUMIDITY_LOW_RST;
      cfg_r.humidity_high <= HUMIDITY_HIGH_RST;
      cfg_r.temp_low      <= TEMP_LOW_RST;
      cfg_r.temp_high     <= TEMP_HIGH_RST;
      cfg_r.heat_on_limit <= HEAT_ON_LIMIT_RST;
      cfg_r.heat_pause    <= HEAT_PAUSE_RST;
      cfg_r.vent_on_limit <= VENT_ON_LIMIT_RST;
      cfg_r.vent_pause    <= VENT_PAUSE_RST;
    end else if (cfg_we) begin
      unique case (hvc_reg_t'(cfg_index))
        REG_HUMIDITY_LOW:  cfg_r.humidity_low  <= cfg_data[HUM_W-1:0];
        REG_HUMIDITY_HIGH: cfg_r.humidity_high <= cfg_data[HUM_W-1:0];
        REG_TEMP_LOW:      cfg_r.temp_low      <= cfg_data[TEMP_W-1:0];
        REG_TEMP_HIGH:     cfg_r.temp_high     <= cfg_data[TEMP_W-1:0];
        REG_HEAT_ON_LIMIT: cfg_r.heat_on_limit <= cfg_data[TIME_W-1:0];
        REG_HEAT_PAUSE:    cfg_r.heat_pause    <= cfg_data[TIME_W-1:0];
        REG_VENT_ON_LIMIT: cfg_r.vent_on_limit <= cfg_data[TIME_W-1:0];
        REG_VENT_PAUSE:    cfg_r.vent_pause    <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_hum_r    <= in_humidity;
      s1_temp_r   <= in_temperature;
      s1_manual_r <= in_manual_mode;
    end
  end

  // One tick of the controller
  hvc_step u_step (
    .cfg         (cfg_r),
    .cur         (st_r),
    .gap_load    (GapLoad),
    .humidity    (s1_hum_r),
    .temperature (s1_temp_r),
    .manual_mode (s1_manual_r),
    .nxt         (st_nxt)
  );

  // Controller state: update once per tick as it moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.heater_on  <= 1'b0;
      st_r.vent_on    <= 1'b0;
      st_r.heater_cnt <= StartHold;
      st_r.vent_cnt   <= StartHold;
      st_r.gap_cnt    <= '0;
      st_r.heater_req <= 1'b0;
      st_r.vent_req   <= 1'b0;
      st_r.heater_out <= 1'b0;
      st_r.vent_out   <= 1'b0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r <= {st_nxt.heater_out, st_nxt.vent_out, st_nxt.heater_on,
                     st_nxt.vent_on, st_nxt.heater_req, st_nxt.vent_req};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_heater_drive   = out_word_r[5];
  assign out_vent_drive     = out_word_r[4];
  assign out_heater_active  = out_word_r[3];
  assign out_vent_active    = out_word_r[2];
  assign out_heater_pending = out_word_r[1];
  assign out_vent_pending   = out_word_r[0];

  // A load is never both driven and pending
  a_drive_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_heater_drive && out_heater_pending) &&
                    !(out_vent_drive && out_vent_pending))
    else $error("load driven and pending at once");

  // Drive or pending requires the machine to be enabled
  a_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!(out_heater_drive || out_heater_pending) || out_heater_active) &&
                    (!(out_vent_drive || out_vent_pending) || out_vent_active))
    else $error("load on or pending while its machine is disabled");

  // Gap timer never exceeds its load value
  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.gap_cnt <= GapLoad)
    else $error("gap timer out of range");

  // State changes only when a tick moves into the output register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(st_r))
    else $error("controller state changed without a tick");

endmodule

// ===== tb/sv/heater_vent_climate_controller_tb.sv =====
`timescale 1ns / 1ps

module heater_vent_climate_controller_tb;
  import hvc_pkg::*;

  localparam int GAP_TICKS   = 10;
  localparam int HOLD_TICKS  = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_COUNT = 14;
  localparam int PHASE_TICKS = 125;

  typedef struct packed {
    logic [HUM_W-1:0]         humidity;
    logic signed [TEMP_W-1:0] temperature;
    logic                     manual_mode;
  } climate_tick_t;

  // Field order matches the result ports, heater_drive in the top bit
  typedef struct packed {
    logic heater_drive;
    logic vent_drive;
    logic heater_active;
    logic vent_active;
    logic heater_pending;
    logic vent_pending;
  } load_status_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [HUM_W-1:0]         in_humidity = '0;
  logic signed [TEMP_W-1:0] in_temperature = '0;
  logic                     in_manual_mode = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_heater_drive;
  logic                     out_vent_drive;
  logic                     out_heater_active;
  logic                     out_vent_active;
  logic                     out_heater_pending;
  logic                     out_vent_pending;

  heater_vent_climate_controller #(
    .LOAD_GAP_TICKS  (GAP_TICKS),
    .START_HOLD_TICKS(HOLD_TICKS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_humidity       (in_humidity),
    .in_temperature    (in_temperature),
    .in_manual_mode    (in_manual_mode),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_heater_drive  (out_heater_drive),
    .out_vent_drive    (out_vent_drive),
    .out_heater_active (out_heater_active),
    .out_vent_active   (out_vent_active),
    .out_heater_pending(out_heater_pending),
    .out_vent_pending  (out_vent_pending)
  );

  always #4 clk = ~clk;

  // Controller mirror: settings and state as the block should hold them
  hvc_cfg_t      climate_cfg;
  hvc_state_t    climate_state;
  load_status_t  expected_status[$];
  climate_tick_t pending_ticks[$];

  int  ticks_issued = 0;
  int  ticks_sent = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  int  rx_hold_cycles = 0;
  bit  tick_taken = 1'b0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  manual_level = 1'b0;

  // Advance the mirror by one tick and queue the status it should report
  task automatic advance_climate(input logic [HUM_W-1:0] hum,
                                 input logic signed [TEMP_W-1:0] temp,
                                 input logic manual);
    logic signed [TEMP_W-1:0] t_low;
    logic signed [TEMP_W-1:0] t_high;
    logic                     heat_done;
    logic                     vent_done;
    load_status_t             status;
    t_low  = climate_cfg.temp_low;
    t_high = climate_cfg.temp_high;

    // count down all timers first
    if (climate_state.heater_cnt != 0) climate_state.heater_cnt = climate_state.heater_cnt - 1'b1;
    if (climate_state.vent_cnt != 0) climate_state.vent_cnt = climate_state.vent_cnt - 1'b1;
    if (climate_state.gap_cnt != 0) climate_state.gap_cnt = climate_state.gap_cnt - 1'b1;
    heat_done = (climate_state.heater_cnt == 0);
    vent_done = (climate_state.vent_cnt == 0);

    // heater: request on when cold, or humid and not warm; drop at once
    if (!climate_state.heater_on) begin
      if (heat_done && (temp < t_low || (hum > climate_cfg.humidity_high && temp < t_high))) begin
        climate_state.heater_cnt = climate_cfg.heat_on_limit;
        climate_state.heater_req = 1'b1;
        climate_state.heater_on  = 1'b1;
      end
    end else if (heat_done || temp > t_high) begin
      climate_state.heater_cnt = climate_cfg.heat_pause;
      climate_state.heater_req = 1'b0;
      climate_state.heater_out = 1'b0;
      climate_state.heater_on  = 1'b0;
    end

    // vent: manual forces it on without touching the timer
    if (!climate_state.vent_on) begin
      if (vent_done && hum > climate_cfg.humidity_high) begin
        climate_state.vent_cnt = climate_cfg.vent_on_limit;
        climate_state.vent_req = 1'b1;
        climate_state.vent_on  = 1'b1;
      end
      if (manual) begin
        climate_state.vent_req = 1'b1;
        climate_state.vent_on  = 1'b1;
      end
    end else if ((vent_done || hum < climate_cfg.humidity_low) && !manual) begin
      climate_state.vent_cnt = climate_cfg.vent_pause;
      climate_state.vent_req = 1'b0;
      climate_state.vent_out = 1'b0;
      climate_state.vent_on  = 1'b0;
    end

    // sequencer: heater before vent, one switch-on per gap
    if (climate_state.gap_cnt == 0) begin
      if (climate_state.heater_req) begin
        climate_state.heater_out = 1'b1;
        climate_state.heater_req = 1'b0;
        climate_state.gap_cnt    = GAP_TICKS[GAP_W-1:0];
      end else if (climate_state.vent_req) begin
        climate_state.vent_out = 1'b1;
        climate_state.vent_req = 1'b0;
        climate_state.gap_cnt  = GAP_TICKS[GAP_W-1:0];
      end
    end

    status.heater_drive   = climate_state.heater_out;
    status.vent_drive     = climate_state.vent_out;
    status.heater_active  = climate_state.heater_on;
    status.vent_active    = climate_state.vent_on;
    status.heater_pending = climate_state.heater_req;
    status.vent_pending   = climate_state.vent_req;
    expected_status.push_back(status);
  endtask

  task automatic queue_tick(input int hum, input int temp, input bit manual);
    climate_tick_t t;
    t.humidity    = hum[HUM_W-1:0];
    t.temperature = temp[TEMP_W-1:0];
    t.manual_mode = manual;
    pending_ticks.push_back(t);
    ticks_issued++;
  endtask

  // Mostly values around the thresholds, the rest anywhere in the field
  task automatic queue_random_ticks(input int count);
    int hum;
    int temp;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) manual_level = ~manual_level;
      if ($urandom_range(0, 9) < 7) begin
        hum = ($urandom_range(0, 1) ? int'(climate_cfg.humidity_low) :
               int'(climate_cfg.humidity_high)) + int'($urandom_range(0, 8)) - 4;
        temp = ($urandom_range(0, 1) ? int'($signed(climate_cfg.temp_low)) :
                int'($signed(climate_cfg.temp_high))) + int'($urandom_range(0, 6)) - 3;
        if (hum < 0) hum = 0;
        if (hum > 127) hum = 127;
        if (temp < -128) temp = -128;
        if (temp > 127) temp = 127;
      end else begin
        hum  = int'($urandom_range(0, 127));
        temp = int'($urandom_range(0, 255)) - 128;
      end
      queue_tick(hum, temp, manual_level);
    end
  endtask

  // Register write; bits above the register width carry junk
  task automatic write_reg(input hvc_reg_t idx, input logic [CFG_W-1:0] value,
                           input int width);
    logic [CFG_W-1:0] junk;
    junk = (width < CFG_W) ? (CFG_W'($urandom) << width) : '0;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= junk | value;
  endtask

  task automatic configure(input hvc_cfg_t c);
    write_reg(REG_HUMIDITY_LOW, CFG_W'(c.humidity_low), HUM_W);
    write_reg(REG_HUMIDITY_HIGH, CFG_W'(c.humidity_high), HUM_W);
    write_reg(REG_TEMP_LOW, CFG_W'(c.temp_low), TEMP_W);
    write_reg(REG_TEMP_HIGH, CFG_W'(c.temp_high), TEMP_W);
    write_reg(REG_HEAT_ON_LIMIT, c.heat_on_limit, TIME_W);
    write_reg(REG_HEAT_PAUSE, c.heat_pause, TIME_W);
    write_reg(REG_VENT_ON_LIMIT, c.vent_on_limit, TIME_W);
    write_reg(REG_VENT_PAUSE, c.vent_pause, TIME_W);
    @(negedge clk);
    cfg_we <= 1'b0;
    climate_cfg = c;
  endtask

  // Wait until every word is through and its status has come back
  task automatic wait_idle();
    while (ticks_sent != ticks_issued || expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic hvc_cfg_t random_settings();
    hvc_cfg_t c;
    c.humidity_low  = HUM_W'($urandom_range(0, 100));
    c.humidity_high = HUM_W'(int'(c.humidity_low) + int'($urandom_range(0, 12)));
    c.temp_low      = TEMP_W'(int'($urandom_range(0, 50)) - 20);
    c.temp_high     = TEMP_W'(int'($signed(c.temp_low)) + int'($urandom_range(0, 8)));
    // now and then inverted or arbitrary thresholds
    if ($urandom_range(0, 5) == 0) begin
      c.humidity_low  = HUM_W'($urandom);
      c.humidity_high = HUM_W'($urandom);
      c.temp_low      = TEMP_W'($urandom);
      c.temp_high     = TEMP_W'($urandom);
    end
    c.heat_on_limit = TIME_W'($urandom_range(0, 40));
    c.heat_pause    = TIME_W'($urandom_range(0, 40));
    c.vent_on_limit = TIME_W'($urandom_range(0, 40));
    c.vent_pause    = TIME_W'($urandom_range(0, 40));
    return c;
  endfunction

  // Drive input words; hold each until taken, then idle the drawn gap
  always @(negedge clk) begin : tick_driver
    climate_tick_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !tick_taken) begin
      // hold the current word
    end else if (tx_wait > 0) begin
      tx_wait--;
      in_valid <= 1'b0;
    end else if (pending_ticks.size() != 0) begin
      t = pending_ticks.pop_front();
      in_humidity    <= t.humidity;
      in_temperature <= t.temperature;
      in_manual_mode <= t.manual_mode;
      in_valid       <= 1'b1;
      tx_wait = tx_idle_on ? int'($urandom_range(0, 14)) : 0;
    end else begin
      in_valid <= 1'b0;
    end
    tick_taken = 1'b0;
  end

  // Drive ready: long hold-off first, then the per-word wait
  always @(negedge clk) begin : status_receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) rx_hold_cycles--;
  end

  // Predict on every accepted tick, check every accepted status word
  always @(posedge clk) begin : status_monitor
    load_status_t got;
    load_status_t want;
    string        fname;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        advance_climate(in_humidity, in_temperature, in_manual_mode);
        ticks_sent++;
        tick_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = {out_heater_drive, out_vent_drive, out_heater_active, out_vent_active,
               out_heater_pending, out_vent_pending};
        if (expected_status.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected status word %b", got);
        end else begin
          want = expected_status.pop_front();
          for (int i = 5; i >= 0; i--) begin
            if (got[i] !== want[i]) begin
              error_count++;
              case (i)
                5: fname = "heater_drive";
                4: fname = "vent_drive";
                3: fname = "heater_active";
                2: fname = "vent_active";
                1: fname = "heater_pending";
                default: fname = "vent_pending";
              endcase
              if (error_count <= 10)
                $display("mismatch at status %0d, %s: expected %b, got %b",
                         ticks_sent - expected_status.size() - 1, fname, want[i], got[i]);
            end
          end
        end
        rx_wait = rx_idle_on ? int'($urandom_range(0, 14)) : 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    hvc_cfg_t c;
    climate_cfg.humidity_low  = HUMIDITY_LOW_RST;
    climate_cfg.humidity_high = HUMIDITY_HIGH_RST;
    climate_cfg.temp_low      = TEMP_LOW_RST;
    climate_cfg.temp_high     = TEMP_HIGH_RST;
    climate_cfg.heat_on_limit = HEAT_ON_LIMIT_RST;
    climate_cfg.heat_pause    = HEAT_PAUSE_RST;
    climate_cfg.vent_on_limit = VENT_ON_LIMIT_RST;
    climate_cfg.vent_pause    = VENT_PAUSE_RST;
    climate_state            = '0;
    climate_state.heater_cnt = HOLD_TICKS[TIME_W-1:0];
    climate_state.vent_cnt   = HOLD_TICKS[TIME_W-1:0];

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: field extremes and manual mode inside the start hold
    queue_tick(0, -128, 1'b0);
    queue_tick(127, 127, 1'b0);
    queue_tick(100, 0, 1'b1);
    queue_tick(45, 20, 1'b1);
    queue_tick(46, 24, 1'b0);
    queue_tick(39, -1, 1'b0);
    queue_tick(0, 127, 1'b1);
    queue_tick(101, -2, 1'b0);
    wait_idle();

    // Zero heater on-time and vent pause, one-tick heater pause and vent on-time
    c = climate_cfg;
    c.heat_on_limit = '0;
    c.heat_pause    = 16'd1;
    c.vent_on_limit = 16'd1;
    c.vent_pause    = '0;
    configure(c);
    queue_tick(127, -128, 1'b0);
    queue_tick(0, 127, 1'b0);
    queue_tick(100, -128, 1'b1);
    queue_tick(46, 19, 1'b0);
    queue_tick(46, 23, 1'b1);
    queue_tick(44, 25, 1'b0);
    queue_tick(39, 20, 1'b0);
    queue_tick(50, -5, 1'b1);
    queue_tick(50, -5, 1'b0);
    queue_tick(120, 24, 1'b0);
    queue_tick(0, -128, 1'b1);
    queue_tick(45, 24, 1'b0);
    queue_tick(40, 20, 1'b1);
    queue_tick(41, 21, 1'b0);
    queue_tick(101, -1, 1'b0);
    queue_tick(127, 127, 1'b1);
    queue_tick(1, -127, 1'b0);
    wait_idle();

    // Random phases; extremes first, long timers last so they cannot block
    for (int p = 0; p < PHASE_COUNT; p++) begin
      c = random_settings();
      if (p == 0) begin
        c.humidity_low  = 7'd127;
        c.humidity_high = 7'd0;
        c.temp_low      = 8'sd127;
        c.temp_high     = -8'sd128;
        c.heat_on_limit = '0;
        c.heat_pause    = '0;
        c.vent_on_limit = '0;
        c.vent_pause    = '0;
      end else if (p == 1) begin
        c.humidity_low  = 7'd0;
        c.humidity_high = 7'd127;
        c.temp_low      = -8'sd128;
        c.temp_high     = 8'sd127;
        c.heat_on_limit = 16'd1;
        c.heat_pause    = 16'd1;
        c.vent_on_limit = 16'd1;
        c.vent_pause    = 16'd1;
      end else if (p == PHASE_COUNT - 2) begin
        c.heat_on_limit = 16'hFFFF;
        c.vent_on_limit = 16'hFFFF;
      end else if (p == PHASE_COUNT - 1) begin
        c.heat_on_limit = 16'hFFFF;
        c.heat_pause    = 16'hFFFF;
        c.vent_on_limit = 16'hFFFF;
        c.vent_pause    = 16'hFFFF;
      end
      configure(c);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      // stall the result side long enough to back up the input
      if (p == 4) begin
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 300;
      end
      queue_random_ticks(PHASE_TICKS);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    error_count += expected_status.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hvc_pkg.sv
hw/rtl/hvc_step.sv
hw/rtl/heater_vent_climate_controller.sv
tb/sv/heater_vent_climate_controller_tb.sv
